>>> hw/rtl/swmm_pkg.sv
// Shared types and constants for the sliding-window median/min/max unit.
// Holds the window entry record and the control request broadcast along the cell row.
// No dependencies.
package swmm_pkg;

	localparam int CNT_W            = 16;
	localparam int POS_W            = 32;
	localparam int HALF_WINDOW_DEF  = 16;

	// One window slot: occupancy flag, count and its position tag
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] value;
		logic [POS_W-1:0] pos;
	} entry_t;

	// Broadcast to every cell of a window in the same cycle
	typedef struct packed {
		logic             ins;    // sorted insert of value/pos
		logic             evict;  // remove first entry tagged pos
		logic [CNT_W-1:0] value;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

>>> hw/rtl/swmm_cell.sv
// One slot of a sorted window: holds an entry, shifts right on insert, left on evict.
// Depends on swmm_pkg.
module swmm_cell #(
	parameter bit LAST = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swmm_pkg::cell_ctl_t ctl,
	input  swmm_pkg::entry_t   left,
	input  logic               left_lt,
	input  swmm_pkg::entry_t   right,
	input  logic               prior_hit,
	output swmm_pkg::entry_t   entry,
	output logic               lt,
	output logic               hit
);
	import swmm_pkg::*;

	logic             valid_q;
	logic [CNT_W-1:0] value_q;
	logic [POS_W-1:0] pos_q;
	entry_t           nxt;

	assign entry = '{valid: valid_q, value: value_q, pos: pos_q};

	// last slot never counts as smaller: a full window drops its largest entry
	assign lt  = valid_q && (value_q < ctl.value) && !LAST;
	assign hit = prior_hit || (valid_q && (pos_q == ctl.pos));

	// next slot content
	always_comb begin
		nxt = entry;
		if (ctl.ins) begin
			if (!lt) begin
				if (left_lt) begin
					nxt = '{valid: 1'b1, value: ctl.value, pos: ctl.pos};
				end else begin
					nxt = left;
				end
			end
		end else if (ctl.evict && hit) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		value_q <= nxt.value;
		pos_q   <= nxt.pos;
	end

endmodule

>>> hw/rtl/swmm_window.sv
// Sorted window built as a row of swmm_cell slots, with median/min/max taps.
// Depends on swmm_pkg and swmm_cell.
module swmm_window #(
	parameter int CAP = swmm_pkg::HALF_WINDOW_DEF + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swmm_pkg::cell_ctl_t           ctl,
	output logic [swmm_pkg::CNT_W-1:0]    median,
	output logic [swmm_pkg::CNT_W-1:0]    min_value,
	output logic [swmm_pkg::CNT_W-1:0]    max_value
);
	import swmm_pkg::*;

	entry_t           ents [CAP];
	logic [CAP-1:0]   lts;
	logic [CAP-1:0]   hits;
	logic [2*CAP:0]   vext;

	// cell row
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		entry_t lft;
		entry_t rgt;
		logic   lft_lt;
		logic   prv_hit;

		if (i == 0) begin : g_first
			assign lft     = ents[0];
			assign lft_lt  = 1'b1;
			assign prv_hit = 1'b0;
		end else begin : g_mid
			assign lft     = ents[i-1];
			assign lft_lt  = lts[i-1];
			assign prv_hit = hits[i-1];
		end

		if (i == CAP-1) begin : g_end
			assign rgt = '0;
		end else begin : g_inner
			assign rgt = ents[i+1];
		end

		swmm_cell #(
			.LAST (i == CAP-1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left      (lft),
			.left_lt   (lft_lt),
			.right     (rgt),
			.prior_hit (prv_hit),
			.entry     (ents[i]),
			.lt        (lts[i]),
			.hit       (hits[i])
		);
	end

	// taps: occupancy is a thermometer, so median and last slot are local decodes
	always_comb begin
		vext    = '0;
		vext[0] = 1'b1;
		for (int i = 0; i < CAP; i++) begin
			vext[i+1] = ents[i].valid;
		end
		median    = '0;
		max_value = '0;
		for (int i = 0; i < CAP; i++) begin
			if (vext[2*i] && !vext[2*i+2]) begin
				median = median | ents[i].value;
			end
			if (ents[i].valid && !vext[i+2]) begin
				max_value = max_value | ents[i].value;
			end
		end
		min_value = ents[0].value;
	end

endmodule

>>> hw/rtl/sliding_window_median_min_max_unit.sv
// Sliding-window median/min/max unit: two sorted windows as rows of cells.
// Each accepted request runs an insert pass then an evict pass on the cell rows, and the
// result is registered in the evict pass; no new item is taken until that pass is done;
// a result not yet taken holds the evict pass and with it the input.
// Reset clears window occupancy, start_position, control state and output valid;
// slot contents are not cleared.
module sliding_window_median_min_max_unit #(
	parameter int HALF_WINDOW = swmm_pkg::HALF_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [31:0]                start_position,
	// input requests
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [swmm_pkg::POS_W-1:0] position,
	input  logic [swmm_pkg::CNT_W-1:0] read_ends,
	// results
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [swmm_pkg::POS_W-1:0] out_position,
	output logic [swmm_pkg::CNT_W-1:0] out_count,
	output logic [swmm_pkg::CNT_W-1:0] lambda,
	output logic [swmm_pkg::CNT_W-1:0] short_min,
	output logic [swmm_pkg::CNT_W-1:0] short_median,
	output logic [swmm_pkg::CNT_W-1:0] short_max
);
	import swmm_pkg::*;

	localparam int LONG_CAP  = 2*HALF_WINDOW + 1;
	localparam int SHORT_CAP = HALF_WINDOW + 1;

	typedef enum logic {
		S_IDLE,
		S_EVICT
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic [31:0]      start_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             out_free;
	logic             do_evict;
	logic             long_en;
	logic             short_en;
	logic [POS_W-1:0] long_tag;
	logic [POS_W-1:0] short_tag;
	cell_ctl_t        long_ctl;
	cell_ctl_t        short_ctl;
	logic [CNT_W-1:0] long_med;
	logic [CNT_W-1:0] sh_min;
	logic [CNT_W-1:0] sh_med;
	logic [CNT_W-1:0] sh_max;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign do_evict  = (state_q == S_EVICT) && out_free;

	// eviction thresholds, exact 33-bit compare
	assign long_en   = {1'b0, pos_q} >= ({1'b0, start_q} + 33'(2*HALF_WINDOW));
	assign short_en  = {1'b0, pos_q} >= ({1'b0, start_q} + 33'(HALF_WINDOW));
	assign long_tag  = pos_q - POS_W'(2*HALF_WINDOW);
	assign short_tag = pos_q - POS_W'(HALF_WINDOW);

	// requests to the cell rows
	always_comb begin
		long_ctl.ins    = accept;
		long_ctl.evict  = do_evict && long_en;
		long_ctl.value  = read_ends;
		long_ctl.pos    = accept ? position : long_tag;
		short_ctl.ins   = accept;
		short_ctl.evict = do_evict && short_en;
		short_ctl.value = read_ends;
		short_ctl.pos   = accept ? position : short_tag;
	end

	swmm_window #(
		.CAP (LONG_CAP)
	) u_long (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (long_ctl),
		.median    (long_med),
		.min_value (),
		.max_value ()
	);

	swmm_window #(
		.CAP (SHORT_CAP)
	) u_short (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (short_ctl),
		.median    (sh_med),
		.min_value (sh_min),
		.max_value (sh_max)
	);

	// control state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			start_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				start_q <= start_position;
			end
			unique case (state_q)
				S_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= S_EVICT;
					end
				end
				S_EVICT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item hold and result payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
			cnt_q <= read_ends;
		end
		if (do_evict) begin
			out_position <= pos_q;
			out_count    <= cnt_q;
			lambda       <= long_med;
			short_min    <= sh_min;
			short_median <= sh_med;
			short_max    <= sh_max;
		end
	end

`ifndef SYNTHESIS
	// input not ready in the cycle after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in consecutive cycles");

	// a new result only comes out of the evict pass
	a_result_from_evict: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EVICT))
		else $error("result raised outside evict pass");

	// short window result taps stay in order: min, median, max
	a_short_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (short_min <= short_median) && (short_median <= short_max))
		else $error("short window taps out of order");
`endif

endmodule
